>>> design/pffr_pkg.sv
// Shared constants and types for the FIFO page replacer.
`default_nettype none

package pffr_pkg;

    localparam int DEF_MAX_PAGES  = 256;
    localparam int DEF_MAX_FRAMES = 64;

    localparam logic CMD_FAULT = 1'b0;
    localparam logic CMD_MARK  = 1'b1;

    localparam logic REG_PAGES_IN_USE  = 1'b0;
    localparam logic REG_FRAMES_IN_USE = 1'b1;

    localparam logic [8:0] PAGES_RESET  = 9'd256;
    localparam logic [6:0] FRAMES_RESET = 7'd64;

    localparam logic [2:0] ST_FREE_FILLED = 3'd0;
    localparam logic [2:0] ST_REPLACED    = 3'd1;
    localparam logic [2:0] ST_RESIDENT    = 3'd2;
    localparam logic [2:0] ST_DIRTY       = 3'd3;
    localparam logic [2:0] ST_BAD         = 3'd4;

    localparam logic [31:0] DISK_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  owner;
        logic [15:0] stamp;
    } pffr_frame_entry_t;

endpackage

`default_nettype wire

>>> design/pffr_page_mem.sv
// Page table memory with one write port and one registered read port.
`default_nettype none

module pffr_page_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 8
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/pffr_frame_table.sv
// Frame table: used flags in flip-flops, owner and fill stamp in a memory.
`default_nettype none

module pffr_frame_table
    import pffr_pkg::*;
#(
    parameter int NUM_FRAMES = 64,
    parameter int FW         = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [FW-1:0]     wr_addr,
    input  wire pffr_frame_entry_t wr_entry,
    input  wire logic [FW-1:0]     rd_addr,
    output logic                   rd_used,
    output pffr_frame_entry_t      rd_entry
);

    logic [NUM_FRAMES-1:0] used_reg;
    pffr_frame_entry_t     mem [NUM_FRAMES];
    pffr_frame_entry_t     rd_entry_reg;
    logic                  rd_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (wr_en)
        begin
            used_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
        rd_used_reg  <= used_reg[rd_addr];
    end

    assign rd_used  = rd_used_reg;
    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

>>> design/pffr_scan_unit.sv
// Scan unit that finds the lowest free frame and the oldest filled frame.
`default_nettype none

module pffr_scan_unit
    import pffr_pkg::*;
#(
    parameter int FW = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_vld,
    input  wire logic [FW-1:0]     sample_idx,
    input  wire logic              sample_used,
    input  wire pffr_frame_entry_t sample_entry,
    input  wire logic [15:0]       fill_count,
    output logic                   found_free,
    output logic      [FW-1:0]     free_idx,
    output logic      [FW-1:0]     best_idx,
    output logic      [7:0]        best_owner
);

    logic          found_free_reg;
    logic          found_free_next;
    logic [FW-1:0] free_idx_reg;
    logic [FW-1:0] free_idx_next;
    logic [15:0]   best_age_reg;
    logic [15:0]   best_age_next;
    logic [FW-1:0] best_idx_reg;
    logic [FW-1:0] best_idx_next;
    logic [7:0]    best_owner_reg;
    logic [7:0]    best_owner_next;
    logic [15:0]   age;
    logic          first;

    assign age   = fill_count - sample_entry.stamp;
    assign first = (sample_idx == '0);

    always_comb
    begin
        found_free_next = found_free_reg;
        free_idx_next   = free_idx_reg;
        best_age_next   = best_age_reg;
        best_idx_next   = best_idx_reg;
        best_owner_next = best_owner_reg;
        if (sample_vld)
        begin
            if (first)
            begin
                found_free_next = !sample_used;
                free_idx_next   = sample_idx;
            end
            else if (!found_free_reg && !sample_used)
            begin
                found_free_next = 1'b1;
                free_idx_next   = sample_idx;
            end
            if (first || (age > best_age_reg))
            begin
                best_age_next   = age;
                best_idx_next   = sample_idx;
                best_owner_next = sample_entry.owner;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_free_reg <= 1'b0;
        end
        else
        begin
            found_free_reg <= found_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg   <= free_idx_next;
        best_age_reg   <= best_age_next;
        best_idx_reg   <= best_idx_next;
        best_owner_reg <= best_owner_next;
    end

    assign found_free = found_free_reg;
    assign free_idx   = free_idx_reg;
    assign best_idx   = best_idx_reg;
    assign best_owner = best_owner_reg;

endmodule

`default_nettype wire

>>> design/page_fault_fifo_replacer.sv
// Top level of the FIFO page replacer: sequencer, configuration and result register.
`default_nettype none

// Services page faults and write marks one at a time. After reset the page table is
// cleared one entry after another, during which no input transfer is taken. For a
// write mark, a fault on a resident page or an out-of-range page, the result appears
// in the same cycle as the next input can be taken. A fault that fills a frame reads
// the page table, scans the effective frame count of entries, drains, chooses a
// frame, evicts the victim page when no frame is free and fills the frame; the frame
// scan reads one frame table entry per cycle through a single age compare unit. The
// next input is taken while a result still waits in the output register, but not
// while one waits to enter it.
module page_fault_fifo_replacer
    import pffr_pkg::*;
#(
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [7:0]  page_number,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [2:0]  status,
    output logic      [5:0]  frame_number,
    output logic             victim_valid,
    output logic      [7:0]  victim_page,
    output logic             wrote_back,
    output logic      [31:0] disk_accesses
);

    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int DW = FW + 2;
    localparam logic [PW-1:0] LAST_PAGE = PW'(MAX_PAGES - 1);
    localparam logic [8:0]    FRAMES_CAP = 9'(MAX_FRAMES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PAGE,
        S_SCAN,
        S_DRAIN,
        S_CHOOSE,
        S_EVICT,
        S_FILL
    } state_t;

    state_t state_reg, state_next;
    logic            done_pending_reg, done_pending_next;
    logic [PW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            cmd_reg, cmd_next;
    logic [7:0]      page_reg, page_next;
    logic [FW-1:0]   scan_idx_reg, scan_idx_next;
    logic            sample_vld_reg, sample_vld_next;
    logic [FW-1:0]   sample_idx_reg, sample_idx_next;
    logic [FW-1:0]   target_reg, target_next;
    logic [15:0]     fill_counter_reg, fill_counter_next;
    logic [31:0]     disk_count_reg, disk_count_next;
    logic [8:0]      pages_in_use_reg, pages_in_use_next;
    logic [6:0]      frames_in_use_reg, frames_in_use_next;
    logic [2:0]      res_status_reg, res_status_next;
    logic [5:0]      res_frame_reg, res_frame_next;
    logic            res_vvalid_reg, res_vvalid_next;
    logic [7:0]      res_vpage_reg, res_vpage_next;
    logic            res_wb_reg, res_wb_next;
    logic            out_valid_reg, out_valid_next;
    logic [2:0]      out_status_reg, out_status_next;
    logic [5:0]      out_frame_reg, out_frame_next;
    logic            out_vvalid_reg, out_vvalid_next;
    logic [7:0]      out_vpage_reg, out_vpage_next;
    logic            out_wb_reg, out_wb_next;
    logic [31:0]     out_disk_reg, out_disk_next;

    logic            pm_we;
    logic [PW-1:0]   pm_waddr;
    logic [DW-1:0]   pm_wdata;
    logic [PW-1:0]   pm_raddr;
    logic [DW-1:0]   pm_rdata;
    logic            pm_valid;
    logic            pm_dirty;
    logic [FW-1:0]   pm_frame;

    logic              ft_we;
    pffr_frame_entry_t ft_wentry;
    logic              ft_used;
    pffr_frame_entry_t ft_rentry;

    logic            sc_found_free;
    logic [FW-1:0]   sc_free_idx;
    logic [FW-1:0]   sc_best_idx;
    logic [7:0]      sc_best_owner;

    logic [8:0]      nframes;
    logic [FW-1:0]   last_frame;
    logic            in_range;
    logic [32:0]     disk_sum;
    logic            in_xfer;
    logic            out_xfer;

    assign pm_valid = pm_rdata[DW-1];
    assign pm_dirty = pm_rdata[DW-2];
    assign pm_frame = pm_rdata[FW-1:0];

    always_comb
    begin
        if (frames_in_use_reg == 7'd0)
        begin
            nframes = 9'd1;
        end
        else if ({2'b00, frames_in_use_reg} > FRAMES_CAP)
        begin
            nframes = FRAMES_CAP;
        end
        else
        begin
            nframes = {2'b00, frames_in_use_reg};
        end
    end

    assign last_frame = FW'(nframes - 9'd1);
    assign in_range   = ({1'b0, page_number} < pages_in_use_reg) &&
                        ({24'd0, page_number} < 32'(MAX_PAGES));
    assign disk_sum   = {1'b0, disk_count_reg} + (res_wb_reg ? 33'd2 : 33'd1);
    assign in_stall   = (state_reg != S_IDLE) || done_pending_reg;
    assign in_xfer    = in_valid && !in_stall;
    assign out_xfer   = out_valid_reg && !out_stall;

    pffr_page_mem #(
        .DEPTH   (MAX_PAGES),
        .AW      (PW),
        .DW      (DW)
    ) u_page_mem (
        .clk     (clk),
        .wr_en   (pm_we),
        .wr_addr (pm_waddr),
        .wr_data (pm_wdata),
        .rd_addr (pm_raddr),
        .rd_data (pm_rdata)
    );

    pffr_frame_table #(
        .NUM_FRAMES (MAX_FRAMES),
        .FW         (FW)
    ) u_frame_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (ft_we),
        .wr_addr    (target_reg),
        .wr_entry   (ft_wentry),
        .rd_addr    (scan_idx_reg),
        .rd_used    (ft_used),
        .rd_entry   (ft_rentry)
    );

    pffr_scan_unit #(
        .FW           (FW)
    ) u_scan_unit (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_vld   (sample_vld_reg),
        .sample_idx   (sample_idx_reg),
        .sample_used  (ft_used),
        .sample_entry (ft_rentry),
        .fill_count   (fill_counter_reg),
        .found_free   (sc_found_free),
        .free_idx     (sc_free_idx),
        .best_idx     (sc_best_idx),
        .best_owner   (sc_best_owner)
    );

    assign ft_wentry.owner = page_reg;
    assign ft_wentry.stamp = fill_counter_reg;

    always_comb
    begin
        state_next         = state_reg;
        done_pending_next  = done_pending_reg;
        clr_cnt_next       = clr_cnt_reg;
        cmd_next           = cmd_reg;
        page_next          = page_reg;
        scan_idx_next      = scan_idx_reg;
        sample_vld_next    = (state_reg == S_SCAN);
        sample_idx_next    = scan_idx_reg;
        target_next        = target_reg;
        fill_counter_next  = fill_counter_reg;
        disk_count_next    = disk_count_reg;
        pages_in_use_next  = pages_in_use_reg;
        frames_in_use_next = frames_in_use_reg;
        res_status_next    = res_status_reg;
        res_frame_next     = res_frame_reg;
        res_vvalid_next    = res_vvalid_reg;
        res_vpage_next     = res_vpage_reg;
        res_wb_next        = res_wb_reg;
        out_valid_next     = out_valid_reg && !out_xfer;
        out_status_next    = out_status_reg;
        out_frame_next     = out_frame_reg;
        out_vvalid_next    = out_vvalid_reg;
        out_vpage_next     = out_vpage_reg;
        out_wb_next        = out_wb_reg;
        out_disk_next      = out_disk_reg;
        pm_we              = 1'b0;
        pm_waddr           = PW'(page_reg);
        pm_wdata           = '0;
        pm_raddr           = PW'(page_number);
        ft_we              = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PAGES_IN_USE:  pages_in_use_next  = cfg_data;
                REG_FRAMES_IN_USE: frames_in_use_next = cfg_data[6:0];
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                pm_we        = 1'b1;
                pm_waddr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next        = cmd;
                    page_next       = page_number;
                    res_status_next = ST_BAD;
                    res_frame_next  = '0;
                    res_vvalid_next = 1'b0;
                    res_vpage_next  = '0;
                    res_wb_next     = 1'b0;
                    if (in_range)
                    begin
                        state_next = S_PAGE;
                    end
                    else
                    begin
                        done_pending_next = 1'b1;
                    end
                end
            end
            S_PAGE:
            begin
                state_next = S_IDLE;
                if (cmd_reg == CMD_MARK)
                begin
                    if (pm_valid)
                    begin
                        pm_we           = 1'b1;
                        pm_wdata        = {2'b11, pm_frame};
                        res_status_next = ST_DIRTY;
                        res_frame_next  = 6'(pm_frame);
                    end
                    done_pending_next = 1'b1;
                end
                else if (pm_valid)
                begin
                    res_status_next   = ST_RESIDENT;
                    res_frame_next    = 6'(pm_frame);
                    done_pending_next = 1'b1;
                end
                else
                begin
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == last_frame)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_CHOOSE;
            end
            S_CHOOSE:
            begin
                if (sc_found_free)
                begin
                    target_next     = sc_free_idx;
                    res_status_next = ST_FREE_FILLED;
                    state_next      = S_FILL;
                end
                else
                begin
                    target_next     = sc_best_idx;
                    res_status_next = ST_REPLACED;
                    res_vvalid_next = 1'b1;
                    res_vpage_next  = sc_best_owner;
                    pm_raddr        = PW'(sc_best_owner);
                    state_next      = S_EVICT;
                end
            end
            S_EVICT:
            begin
                res_wb_next = pm_dirty;
                pm_we       = 1'b1;
                pm_waddr    = PW'(res_vpage_reg);
                pm_wdata    = '0;
                state_next  = S_FILL;
            end
            S_FILL:
            begin
                pm_we             = 1'b1;
                pm_waddr          = PW'(page_reg);
                pm_wdata          = {2'b10, target_reg};
                ft_we             = 1'b1;
                fill_counter_next = fill_counter_reg + 16'd1;
                disk_count_next   = disk_sum[32] ? DISK_MAX : disk_sum[31:0];
                res_frame_next    = 6'(target_reg);
                done_pending_next = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_pending_reg && (!out_valid_reg || !out_stall))
        begin
            done_pending_next = 1'b0;
            out_valid_next    = 1'b1;
            out_status_next   = res_status_reg;
            out_frame_next    = res_frame_reg;
            out_vvalid_next   = res_vvalid_reg;
            out_vpage_next    = res_vpage_reg;
            out_wb_next       = res_wb_reg;
            out_disk_next     = disk_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            done_pending_reg  <= 1'b0;
            clr_cnt_reg       <= '0;
            cmd_reg           <= CMD_FAULT;
            page_reg          <= '0;
            scan_idx_reg      <= '0;
            sample_vld_reg    <= 1'b0;
            sample_idx_reg    <= '0;
            target_reg        <= '0;
            fill_counter_reg  <= '0;
            disk_count_reg    <= '0;
            pages_in_use_reg  <= PAGES_RESET;
            frames_in_use_reg <= FRAMES_RESET;
            res_status_reg    <= ST_BAD;
            res_frame_reg     <= '0;
            res_vvalid_reg    <= 1'b0;
            res_vpage_reg     <= '0;
            res_wb_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_status_reg    <= ST_BAD;
            out_frame_reg     <= '0;
            out_vvalid_reg    <= 1'b0;
            out_vpage_reg     <= '0;
            out_wb_reg        <= 1'b0;
            out_disk_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            done_pending_reg  <= done_pending_next;
            clr_cnt_reg       <= clr_cnt_next;
            cmd_reg           <= cmd_next;
            page_reg          <= page_next;
            scan_idx_reg      <= scan_idx_next;
            sample_vld_reg    <= sample_vld_next;
            sample_idx_reg    <= sample_idx_next;
            target_reg        <= target_next;
            fill_counter_reg  <= fill_counter_next;
            disk_count_reg    <= disk_count_next;
            pages_in_use_reg  <= pages_in_use_next;
            frames_in_use_reg <= frames_in_use_next;
            res_status_reg    <= res_status_next;
            res_frame_reg     <= res_frame_next;
            res_vvalid_reg    <= res_vvalid_next;
            res_vpage_reg     <= res_vpage_next;
            res_wb_reg        <= res_wb_next;
            out_valid_reg     <= out_valid_next;
            out_status_reg    <= out_status_next;
            out_frame_reg     <= out_frame_next;
            out_vvalid_reg    <= out_vvalid_next;
            out_vpage_reg     <= out_vpage_next;
            out_wb_reg        <= out_wb_next;
            out_disk_reg      <= out_disk_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign frame_number  = out_frame_reg;
    assign victim_valid  = out_vvalid_reg;
    assign victim_page   = out_vpage_reg;
    assign wrote_back    = out_wb_reg;
    assign disk_accesses = out_disk_reg;

    a_disk_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (disk_count_reg >= $past(disk_count_reg)))
        else $error("disk access count decreased");

    a_fill_only_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FILL) |=> (fill_counter_reg == $past(fill_counter_reg)))
        else $error("fill counter moved outside a frame fill");

    a_victim_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_vvalid_reg == (out_status_reg == ST_REPLACED)))
        else $error("victim flag disagrees with status");

    a_writeback_needs_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_wb_reg) |-> out_vvalid_reg)
        else $error("write-back reported without a victim");

endmodule

`default_nettype wire
